### sv/matrix_multiply_engine_macros.svh
// assertion macros for the matrix multiply engine
// expect clk and arst_n in the scope where they are used
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MME_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/mme_pkg.sv
// types and constants shared by the matrix multiply engine
// no dependencies
package mme_pkg;

	localparam logic [1:0] OP_LOAD_A  = 2'd0;
	localparam logic [1:0] OP_LOAD_B  = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	localparam logic [1:0] REG_ROWS_A    = 2'd0;
	localparam logic [1:0] REG_INNER_LEN = 2'd1;
	localparam logic [1:0] REG_COLS_B    = 2'd2;

	// exact sum of up to eight q16.16 products
	localparam int ACC_W = 36;
	localparam int RND_HALF = 128;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [5:0]         elem_index;
		logic signed [15:0] elem_value;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] product_value;
		logic [2:0]         out_row;
		logic [2:0]         out_col;
		logic               saturated;
		logic               last;
	} out_word_t;

	typedef struct packed {
		logic [3:0] m;
		logic [3:0] k;
		logic [3:0] n;
	} dims_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} issue_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] value;
		logic               sat;
	} mac_res_t;

endpackage

### sv/mme_store.sv
// single-port-write, single-port-read element store, registered read
// no dependencies
module mme_store #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic signed [15:0]   wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic signed [15:0]   rd_data
);

	logic signed [15:0] mem [DEPTH];
	logic signed [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### sv/mme_mac.sv
// multiply-accumulate unit with rounding and saturation to q8.8
// depends on mme_pkg
module mme_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  mme_pkg::issue_t     issue,
	input  logic signed [15:0]  a_data,
	input  logic signed [15:0]  b_data,
	output mme_pkg::mac_res_t   res
);

	import mme_pkg::*;

	issue_t                   ctl_s1;
	issue_t                   ctl_s2;
	logic signed [31:0]       prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;
	logic signed [ACC_W-1:0]  rnd;
	logic [ACC_W-9:0]         q;
	logic [ACC_W-9:15]        hi;
	logic                     sat;

	// control travels alongside the store read and the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= issue;
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.vld && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_data * b_data;
		if (ctl_s2.vld) begin
			if (ctl_s2.first) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// round half up, then clamp
	assign rnd = acc_q + ACC_W'(RND_HALF);
	assign q   = rnd[ACC_W-1:8];
	assign hi  = q[ACC_W-9:15];
	assign sat = !((&hi) || !(|hi));

	always_comb begin
		res.done = done_q;
		res.sat  = sat;
		if (sat) begin
			res.value = q[ACC_W-9] ? 16'sh8000 : 16'sh7fff;
		end else begin
			res.value = q[15:0];
		end
	end

endmodule

### sv/mme_ctrl.sv
// sequencer: input handshake, store writes, read address generation,
// result register; depends on mme_pkg
module mme_ctrl #(
	parameter int AW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mme_pkg::dims_t       dims,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mme_pkg::in_word_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mme_pkg::out_word_t   out_data,
	output logic                 a_wr_en,
	output logic                 b_wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic signed [15:0]   wr_data,
	output logic [AW-1:0]        a_rd_addr,
	output logic [AW-1:0]        b_rd_addr,
	output mme_pkg::issue_t      issue,
	input  mme_pkg::mac_res_t    res
);

	import mme_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]    state_q;
	logic [2:0]    i_q;
	logic [2:0]    j_q;
	logic [2:0]    t_q;
	logic [AW-1:0] row_base_q;
	logic [AW-1:0] a_addr_q;
	logic [AW-1:0] b_addr_q;
	logic          out_valid_q;
	out_word_t     out_data_q;
	logic          accept;
	logic          slot_free;
	logic          emit;
	logic          last_row;
	logic          last_col;
	logic          last_term;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = (state_q == ST_EMIT) && slot_free;
	assign last_row  = ({1'b0, i_q} == dims.m - 4'd1);
	assign last_col  = ({1'b0, j_q} == dims.n - 4'd1);
	assign last_term = ({1'b0, t_q} == dims.k - 4'd1);

	// loads outside the configured size are dropped
	assign a_wr_en = accept && (in_data.opcode == OP_LOAD_A) &&
		({2'b00, in_data.elem_index} < (8'(dims.m) * 8'(dims.k)));
	assign b_wr_en = accept && (in_data.opcode == OP_LOAD_B) &&
		({2'b00, in_data.elem_index} < (8'(dims.k) * 8'(dims.n)));
	assign wr_addr = AW'(in_data.elem_index);
	assign wr_data = in_data.elem_value;

	assign a_rd_addr   = a_addr_q;
	assign b_rd_addr   = b_addr_q;
	assign issue.vld   = (state_q == ST_ISSUE);
	assign issue.first = (t_q == 3'd0);
	assign issue.last  = last_term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			t_q         <= '0;
			row_base_q  <= '0;
			a_addr_q    <= '0;
			b_addr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_data.opcode == OP_COMPUTE)) begin
						state_q    <= ST_ISSUE;
						i_q        <= '0;
						j_q        <= '0;
						t_q        <= '0;
						row_base_q <= '0;
						a_addr_q   <= '0;
						b_addr_q   <= '0;
					end
				end
				ST_ISSUE: begin
					// a walks along the row, b down the column
					a_addr_q <= a_addr_q + AW'(1);
					b_addr_q <= b_addr_q + AW'(dims.n);
					t_q      <= t_q + 3'd1;
					if (last_term) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (res.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						t_q <= '0;
						if (last_row && last_col) begin
							state_q <= ST_IDLE;
						end else if (last_col) begin
							state_q    <= ST_ISSUE;
							i_q        <= i_q + 3'd1;
							j_q        <= '0;
							row_base_q <= row_base_q + AW'(dims.k);
							a_addr_q   <= row_base_q + AW'(dims.k);
							b_addr_q   <= '0;
						end else begin
							state_q  <= ST_ISSUE;
							j_q      <= j_q + 3'd1;
							a_addr_q <= row_base_q;
							b_addr_q <= AW'(j_q) + AW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.product_value <= res.value;
			out_data_q.saturated     <= res.sat;
			out_data_q.out_row       <= i_q;
			out_data_q.out_col       <= j_q;
			out_data_q.last          <= last_row && last_col;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### sv/matrix_multiply_engine.sv
// top level of the matrix multiply engine: configuration registers,
// element stores, sequencer and mac; depends on mme_pkg and the macro header
//
// usage
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes rows_a (0),
//   inner_len (1) and cols_b (2); cfg_ready is always high, other indexes
//   are dropped. a value of 0 acts as 1, values above MAX_DIM act as MAX_DIM
//   in channel takes one word per item: load A, load B or compute. a load
//   writes the store by row-major index and gives no word; loads beyond
//   the configured size are dropped
//   a compute item streams C = A x B out in row-major order, last marked on
//   the final element. in_ready stays low until the last word of the
//   result is in the output register
//   each result element is built from inner_len store reads, one per cycle
//   through the single read port of each store, then the multiply and
//   accumulate stages and a load of the output register
//   receiver stall: the output register holds its word; the sequencer waits
//   with the finished sum until the register frees, nothing is dropped
//   reset: registers return to 8 by 8 by 8, the channels go idle; store
//   contents are undefined until written and carry no clear pass
`include "matrix_multiply_engine_macros.svh"

module matrix_multiply_engine #(
	parameter int MAX_DIM = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [3:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  mme_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mme_pkg::out_word_t  out_data
);

	import mme_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = $clog2(DEPTH);

	logic [3:0]          rows_a_q;
	logic [3:0]          inner_len_q;
	logic [3:0]          cols_b_q;
	dims_t               dims;
	logic                a_wr_en;
	logic                b_wr_en;
	logic [AW-1:0]       wr_addr;
	logic signed [15:0]  wr_data;
	logic [AW-1:0]       a_rd_addr;
	logic [AW-1:0]       b_rd_addr;
	logic signed [15:0]  a_rd_data;
	logic signed [15:0]  b_rd_data;
	issue_t              issue;
	mac_res_t            res;

	// configuration: the user writes it only while idle; the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= 4'd8;
			inner_len_q <= 4'd8;
			cols_b_q    <= 4'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_LEN: inner_len_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// effective dimensions, clamped to 1 .. MAX_DIM
	function automatic logic [3:0] eff_dim(input logic [3:0] v);
		logic [3:0] r;
		if (v == 4'd0) begin
			r = 4'd1;
		end else if (v > 4'(MAX_DIM)) begin
			r = 4'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign dims.m = eff_dim(rows_a_q);
	assign dims.k = eff_dim(inner_len_q);
	assign dims.n = eff_dim(cols_b_q);

	mme_ctrl #(
		.AW(AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.dims      (dims),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.a_wr_en   (a_wr_en),
		.b_wr_en   (b_wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.a_rd_addr (a_rd_addr),
		.b_rd_addr (b_rd_addr),
		.issue     (issue),
		.res       (res)
	);

	// matrix A store
	mme_store #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_a_store (
		.clk     (clk),
		.wr_en   (a_wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue.vld),
		.rd_addr (a_rd_addr),
		.rd_data (a_rd_data)
	);

	// matrix B store
	mme_store #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_b_store (
		.clk     (clk),
		.wr_en   (b_wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue.vld),
		.rd_addr (b_rd_addr),
		.rd_data (b_rd_data)
	);

	mme_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.a_data (a_rd_data),
		.b_data (b_rd_data),
		.res    (res)
	);

	// no store read while new items are taken
	`MME_ASSERT_NOW(a_no_issue_when_ready, in_ready, !issue.vld, "read issued while accepting")
	// a finished sum is never overtaken by a new read
	`MME_ASSERT_NOW(a_no_issue_on_done, res.done, !issue.vld, "read issued with sum pending")
	// the last term of an element is followed by the drain, not another read
	`MME_ASSERT_NEXT(a_drain_after_last, issue.vld && issue.last, !issue.vld,
		"read issued right after last term")

endmodule
